/* rtl/wams_pkg.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: shared package
// Operation codes, register indexes, widths and the records that travel
// between the command front end, the executor and the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

package wams_pkg;

  // Fixed field widths of the external item and result.
  localparam int unsigned VTX_W     = 5;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned CNT_OUT_W = 6;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_MAX_VERTICES = 32;
  localparam int unsigned DEF_WEIGHT_BITS  = 16;

  // A row scan reports at most this many neighbours.
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Queue depths.
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned RESQ_DEPTH = 2;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_DIRECTED_MODE = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_DEL  = 2'd1,
    OP_HAS  = 2'd2,
    OP_SCAN = 2'd3
  } op_e;

  // Classified command, as queued between the front end and the executor.
  typedef struct packed {
    op_e                op;
    logic               add_ok;
    logic               mirror;
    logic [VTX_W-1:0]   from_vertex;
    logic [VTX_W-1:0]   to_vertex;
    logic signed [WGT_W-1:0] edge_weight;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic                    found;
    logic [VTX_W-1:0]        neighbour;
    logic signed [WGT_W-1:0] neighbour_weight;
    logic [CNT_OUT_W-1:0]    vertex_count;
    logic                    last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/wams_ram.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: generic RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module wams_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/wams_fifo.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: small queue
// A first-in first-out buffer of a few entries with full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module wams_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  localparam int unsigned PW   = $clog2(DEPTH);
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/wams_front.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: command front end
// Classifies incoming transactions and queues them for the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module wams_front import wams_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire logic [1:0]              op_i,
  input  wire logic [VTX_W-1:0]        from_vertex_i,
  input  wire logic [VTX_W-1:0]        to_vertex_i,
  input  wire logic signed [WGT_W-1:0] edge_weight_i,
  input  wire logic                    directed_i,
  output logic                         full_o,
  input  wire logic                    pop_i,
  output cmd_t                         cmd_o,
  output logic                         empty_o
);

  localparam int unsigned CW   = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CMPW = (CW > VTX_W) ? CW : VTX_W;

  cmd_t                     cmd_in;
  logic [$bits(cmd_t)-1:0]  head;

  // An add only writes when both endpoints name a real matrix row. Mirroring
  // a self-loop would rewrite the same entry, so it is dropped here.
  always_comb begin
    cmd_in.op          = op_e'(op_i);
    cmd_in.add_ok      = (CMPW'(from_vertex_i) < CMPW'(MAX_VERTICES)) &&
                         (CMPW'(to_vertex_i) < CMPW'(MAX_VERTICES));
    cmd_in.mirror      = !directed_i && (from_vertex_i != to_vertex_i);
    cmd_in.from_vertex = from_vertex_i;
    cmd_in.to_vertex   = to_vertex_i;
    cmd_in.edge_weight = edge_weight_i;
  end

  wams_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .wdata_i (cmd_in),
    .full_o  (full_o),
    .pop_i   (pop_i),
    .rdata_o (head),
    .empty_o (empty_o)
  );

  assign cmd_o = head;

endmodule

`default_nettype wire

/* rtl/wams_back.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: executor
// Owns the weight matrix and the vertex count and carries out one queued
// command at a time, including the clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module wams_back import wams_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire cmd_t                                cmd_i,
  input  wire logic                                cmd_empty_i,
  output logic                                     cmd_pop_o,
  output res_t                                     res_o,
  output logic                                     res_push_o,
  input  wire logic                                res_full_i,
  output logic                                     clearing_o,
  output logic [$clog2(MAX_VERTICES + 1)-1:0]      count_o
);

  localparam int unsigned VW    = $clog2(MAX_VERTICES);
  localparam int unsigned CW    = $clog2(MAX_VERTICES + 1);
  localparam int unsigned AW    = 2 * VW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned CMPW  = (CW > VTX_W) ? CW : VTX_W;
  localparam int unsigned WX    = (WEIGHT_BITS > WGT_W) ? WEIGHT_BITS : WGT_W;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_WR1   = 8'b0000_0100,
    ST_WR2   = 8'b0000_1000,
    ST_HRD   = 8'b0001_0000,
    ST_SCAN  = 8'b0010_0000,
    ST_FLUSH = 8'b0100_0000,
    ST_RESP  = 8'b1000_0000
  } state_e;

  // Stored weights are read back sign-extended and cut to the result field.
  function automatic logic signed [WGT_W-1:0] to_out(input logic [WEIGHT_BITS-1:0] x);
    logic signed [WX-1:0] rx;
    rx = WX'(signed'(x));
    return rx[WGT_W-1:0];
  endfunction

  state_e                 state_q, state_d;
  cmd_t                   cmd_q, cmd_d;
  logic [CW-1:0]          count_q, count_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic [CW-1:0]          j_q, j_d;
  logic                   rv_q, rv_d;
  logic [VW-1:0]          rj_q, rj_d;
  logic                   pv_q, pv_d;
  logic [VW-1:0]          pj_q, pj_d;
  logic [WEIGHT_BITS-1:0] pw_q, pw_d;
  logic [RES_CNT_W-1:0]   nf_q, nf_d;
  logic                   hv_q, hv_d;

  logic                   we, re;
  logic [AW-1:0]          waddr, raddr;
  logic [WEIGHT_BITS-1:0] wdata, rdata;

  logic [VW-1:0]          a_idx, b_idx, max_idx;
  logic [CW-1:0]          top;
  logic                   a_in, b_in, wr_ok;
  logic signed [WX-1:0]   wx;
  logic [WEIGHT_BITS-1:0] wfit;
  logic                   dnz, need_push, stall, issue, has_found;
  logic [RES_CNT_W-1:0]   nf_inc;

  assign a_idx   = VW'(cmd_q.from_vertex);
  assign b_idx   = VW'(cmd_q.to_vertex);
  assign max_idx = (a_idx > b_idx) ? a_idx : b_idx;
  assign top     = CW'(max_idx) + CW'(1);
  assign a_in    = CMPW'(cmd_q.from_vertex) < CMPW'(count_q);
  assign b_in    = CMPW'(cmd_q.to_vertex) < CMPW'(count_q);
  assign wx      = WX'(cmd_q.edge_weight);
  assign wfit    = wx[WEIGHT_BITS-1:0];
  assign wr_ok   = (cmd_q.op == OP_ADD) ? cmd_q.add_ok : (a_in && b_in);

  // Row scan: one read in flight, and the newest nonzero entry is held back
  // until the next one shows up, so that the final report can carry last.
  assign dnz       = rv_q && (rdata != '0);
  assign need_push = dnz && pv_q;
  assign stall     = need_push && res_full_i;
  assign nf_inc    = nf_q + RES_CNT_W'(dnz);
  assign issue     = a_in && (j_q < count_q) && (nf_inc < RES_CNT_W'(MAX_RESULTS));
  assign has_found = hv_q && (rdata != '0);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    clr_d      = clr_q;
    j_d        = j_q;
    rv_d       = rv_q;
    rj_d       = rj_q;
    pv_d       = pv_q;
    pj_d       = pj_q;
    pw_d       = pw_q;
    nf_d       = nf_q;
    hv_d       = hv_q;
    we         = 1'b0;
    waddr      = {a_idx, b_idx};
    wdata      = (cmd_q.op == OP_ADD) ? wfit : '0;
    re         = 1'b0;
    raddr      = {a_idx, b_idx};
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '{found: 1'b0, neighbour: '0, neighbour_weight: '0,
                   vertex_count: CNT_OUT_W'(count_q), last: 1'b1};

    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          case (cmd_i.op)
            OP_ADD, OP_DEL: state_d = ST_WR1;
            OP_HAS:         state_d = ST_HRD;
            OP_SCAN: begin
              state_d = ST_SCAN;
              j_d     = '0;
              rv_d    = 1'b0;
              pv_d    = 1'b0;
              nf_d    = '0;
            end
            default:        state_d = ST_IDLE;
          endcase
        end
      end
      ST_WR1: begin
        we = wr_ok;
        if ((cmd_q.op == OP_ADD) && cmd_q.add_ok && (top > count_q)) begin
          count_d = top;
        end
        state_d = (wr_ok && cmd_q.mirror) ? ST_WR2 : ST_RESP;
      end
      ST_WR2: begin
        we      = 1'b1;
        waddr   = {b_idx, a_idx};
        state_d = ST_RESP;
      end
      ST_HRD: begin
        re      = 1'b1;
        hv_d    = a_in && b_in;
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (cmd_q.op == OP_HAS) begin
          res_o.found            = has_found;
          res_o.neighbour        = cmd_q.to_vertex;
          res_o.neighbour_weight = has_found ? to_out(rdata) : '0;
        end
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (dnz) begin
            pv_d = 1'b1;
            pj_d = rj_q;
            pw_d = rdata;
            nf_d = nf_inc;
          end
          if (need_push) begin
            res_push_o = 1'b1;
            res_o      = '{found: 1'b1, neighbour: VTX_W'(pj_q),
                           neighbour_weight: to_out(pw_q),
                           vertex_count: CNT_OUT_W'(count_q), last: 1'b0};
          end
          if (issue) begin
            re    = 1'b1;
            raddr = {a_idx, j_q[VW-1:0]};
            rj_d  = j_q[VW-1:0];
            j_d   = j_q + CW'(1);
            rv_d  = 1'b1;
          end else begin
            rv_d    = 1'b0;
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (pv_q) begin
          res_o.found            = 1'b1;
          res_o.neighbour        = VTX_W'(pj_q);
          res_o.neighbour_weight = to_out(pw_q);
        end
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      count_q <= '0;
      clr_q   <= '0;
      j_q     <= '0;
      rv_q    <= 1'b0;
      pv_q    <= 1'b0;
      nf_q    <= '0;
      hv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      clr_q   <= clr_d;
      j_q     <= j_d;
      rv_q    <= rv_d;
      pv_q    <= pv_d;
      nf_q    <= nf_d;
      hv_q    <= hv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rj_q  <= rj_d;
    pj_q  <= pj_d;
    pw_q  <= pw_d;
  end

  wams_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_matrix (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign clearing_o = (state_q == ST_CLEAR);
  assign count_o    = count_q;

endmodule

`default_nettype wire

/* rtl/weighted_adjacency_matrix_store_core.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store
// A weighted graph kept as a square matrix of edge weights, zero meaning no
// edge, with add, delete, has-edge and row-listing operations.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                     Payload
//   -------   ---------  ----------------------------  ------------------------
//   command   in         push / full                   op, from/to vertex, weight
//   result    out        pop / empty                   found, neighbour, weight,
//                                                       vertex count, last
//   config    in/out     psel, penable, pwrite, pready directed_mode at 0x0
//
// Add and delete write the entry, and the mirrored entry when the write is
// mirrored; has edge reads it. A row listing reads the row up to the vertex
// count, one matrix read per cycle while the result queue has room, through the
// single read port of the matrix RAM. After reset the executor sweeps all
// (2**clog2(MAX_VERTICES))**2 entries, one per cycle (1024 at 32 vertices); full
// stays high during that sweep, while configuration writes are taken as usual.
// A full result queue stalls the executor only; the command queue keeps
// taking transactions until it fills.
//
`default_nettype none

module weighted_adjacency_matrix_store_core import wams_pkg::*; #(
  parameter int unsigned MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int unsigned WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Command channel.
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [1:0]              op_i,
  input  wire logic [VTX_W-1:0]        from_vertex_i,
  input  wire logic [VTX_W-1:0]        to_vertex_i,
  input  wire logic signed [WGT_W-1:0] edge_weight_i,
  // Result channel.
  output logic                         empty,
  input  wire logic                    pop,
  output logic                         found_o,
  output logic [VTX_W-1:0]             neighbour_o,
  output logic signed [WGT_W-1:0]      neighbour_weight_o,
  output logic [CNT_OUT_W-1:0]         vertex_count_o,
  output logic                         last_o,
  // Configuration port.
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [APB_ADDR_W-1:0]   paddr,
  input  wire logic [APB_DATA_W-1:0]   pwdata,
  output logic      [APB_DATA_W-1:0]   prdata,
  output logic                         pready
);

  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

  // Configuration register. Only bit 2 of the address selects a register;
  // the byte offset bits are ignored.
  logic directed_q;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == REG_DIRECTED_MODE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      directed_q <= 1'b0;
    end else if (cfg_wr) begin
      directed_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == REG_DIRECTED_MODE) ?
                  {{(APB_DATA_W - 1){1'b0}}, directed_q} : '0;

  // Command front end. Nothing is taken while the matrix is being cleared.
  logic    cmdq_full;
  logic    cmd_empty;
  logic    cmd_pop;
  logic    in_push;
  logic    clearing;
  cmd_t    cmd_head;

  assign full    = cmdq_full || clearing;
  assign in_push = push && !full;

  wams_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (in_push),
    .op_i          (op_i),
    .from_vertex_i (from_vertex_i),
    .to_vertex_i   (to_vertex_i),
    .edge_weight_i (edge_weight_i),
    .directed_i    (directed_q),
    .full_o        (cmdq_full),
    .pop_i         (cmd_pop),
    .cmd_o         (cmd_head),
    .empty_o       (cmd_empty)
  );

  // Executor: the matrix, the vertex count and the operation sequencer.
  res_t          res_new;
  logic          res_push;
  logic          res_full;
  logic [CW-1:0] vcount;

  wams_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res_new),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .clearing_o  (clearing),
    .count_o     (vcount)
  );

  // Result queue: the head entry drives the result ports.
  logic [$bits(res_t)-1:0] res_bits;
  res_t                    res_head;

  wams_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_new),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_bits),
    .empty_o (empty)
  );

  assign res_head           = res_bits;
  assign found_o            = res_head.found;
  assign neighbour_o        = res_head.neighbour;
  assign neighbour_weight_o = res_head.neighbour_weight;
  assign vertex_count_o     = res_head.vertex_count;
  assign last_o             = res_head.last;

  // The executor never hands a result to a full result queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // No command is taken while the matrix is being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full)
    else $error("command channel open during the clearing sweep");

  // The vertex count never shrinks.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (vcount >= $past(vcount)))
    else $error("vertex count decreased");

  // The executor only takes a command that is actually queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Weighted adjacency matrix store: self-checking testbench
// Drives edge commands through the push/full queue interface, and writes the
// edge-direction register over the APB-style port between phases. Each
// accepted command is run through a matrix model in the scoreboard. Every
// popped result is compared, field by field, with the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;
  import wams_pkg::*;

  localparam int unsigned VERTICES    = DEF_MAX_VERTICES;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned DRAIN_LIMIT = 50_000;
  // A full row listing reads the row up to the vertex count in the executor,
  // and this is enough time for any stray result to show up.
  localparam int unsigned SETTLE_CYCLES = 48;
  localparam logic [APB_ADDR_W-1:0] MODE_ADDR = APB_ADDR_W'(4 * int'(REG_DIRECTED_MODE));

  // --------------------------------------------------------------------------
  // Scoreboard: a copy of the matrix and the vertex count, and the queue of
  // results that the block still owes, in the order it has to deliver them.
  // --------------------------------------------------------------------------
  class adjacency_scoreboard;
    logic signed [WGT_W-1:0] weights [VERTICES][VERTICES];
    int unsigned vertex_total;
    bit one_way;
    res_t pending_results[$];
    int unsigned fault_count;

    function new();
      foreach (weights[i, j]) weights[i][j] = '0;
      vertex_total = 0;
      one_way = 1'b0;
      fault_count = 0;
    endfunction

    task report(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fault_count++;
    endtask

    function res_t make_result(logic found, logic [VTX_W-1:0] nb,
                               logic signed [WGT_W-1:0] w, logic last);
      res_t r;
      r.found = found;
      r.neighbour = nb;
      r.neighbour_weight = w;
      r.vertex_count = CNT_OUT_W'(vertex_total);
      r.last = last;
      return r;
    endfunction

    // Adds one result at the back of the list of owed results.
    function void owe_result(res_t r);
      pending_results = {pending_results, r};
    endfunction

    // Applies one accepted command to the matrix model and queues the
    // results that it must produce.
    function void note_command(op_e op, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                               logic signed [WGT_W-1:0] w);
      int unsigned top;
      logic signed [WGT_W-1:0] hit;
      res_t row_hits[$];
      res_t tail;
      case (op)
        OP_ADD: begin
          // Both endpoints always fit in 32 vertices, so the write always lands.
          top = ((a > b) ? a : b) + 1;
          if (top > vertex_total) vertex_total = top;
          weights[a][b] = w;
          if (!one_way) weights[b][a] = w;
          owe_result(make_result(1'b0, '0, '0, 1'b1));
        end
        OP_DEL: begin
          if (a < vertex_total && b < vertex_total) begin
            weights[a][b] = '0;
            if (!one_way) weights[b][a] = '0;
          end
          owe_result(make_result(1'b0, '0, '0, 1'b1));
        end
        OP_HAS: begin
          hit = '0;
          if (a < vertex_total && b < vertex_total) hit = weights[a][b];
          owe_result(make_result(hit != 0, b, hit, 1'b1));
        end
        default: begin
          // Row listing: only columns below the vertex count are visited.
          if (a < vertex_total) begin
            for (int unsigned j = 0; j < vertex_total; j++) begin
              if (weights[a][j] != 0 && row_hits.size() < MAX_RESULTS) begin
                row_hits = {row_hits, make_result(1'b1, VTX_W'(j), weights[a][j], 1'b0)};
              end
            end
          end
          if (row_hits.size() == 0) begin
            owe_result(make_result(1'b0, '0, '0, 1'b1));
          end else begin
            tail = row_hits[row_hits.size() - 1];
            tail.last = 1'b1;
            row_hits[row_hits.size() - 1] = tail;
            foreach (row_hits[k]) owe_result(row_hits[k]);
          end
        end
      endcase
    endfunction

    task check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        report($sformatf("result with nothing pending: found=%0b nb=%0d w=%0d cnt=%0d last=%0b",
                         got.found, got.neighbour, got.neighbour_weight,
                         got.vertex_count, got.last));
      end else begin
        want = pending_results.pop_front();
        if (got.found !== want.found || got.neighbour !== want.neighbour ||
            got.neighbour_weight !== want.neighbour_weight ||
            got.vertex_count !== want.vertex_count || got.last !== want.last) begin
          report($sformatf("got found=%0b nb=%0d w=%0d cnt=%0d last=%0b, want %0b %0d %0d %0d %0b",
                           got.found, got.neighbour, got.neighbour_weight,
                           got.vertex_count, got.last, want.found, want.neighbour,
                           want.neighbour_weight, want.vertex_count, want.last));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Signals to and from the block under test.
  // --------------------------------------------------------------------------
  logic                    clk_i;
  logic                    rst_ni;
  logic                    push;
  logic                    full;
  logic [1:0]              op_i;
  logic [VTX_W-1:0]        from_vertex_i;
  logic [VTX_W-1:0]        to_vertex_i;
  logic signed [WGT_W-1:0] edge_weight_i;
  logic                    empty;
  logic                    pop;
  logic                    found_o;
  logic [VTX_W-1:0]        neighbour_o;
  logic signed [WGT_W-1:0] neighbour_weight_o;
  logic [CNT_OUT_W-1:0]    vertex_count_o;
  logic                    last_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_ADDR_W-1:0]   paddr;
  logic [APB_DATA_W-1:0]   pwdata;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  adjacency_scoreboard sb;
  int unsigned cycle_count;
  // While a calm flag is set, that side of the block runs without gaps.
  bit sender_calm;
  bit sink_calm;
  int unsigned stall_left;

  weighted_adjacency_matrix_store_core u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .push               (push),
    .full               (full),
    .op_i               (op_i),
    .from_vertex_i      (from_vertex_i),
    .to_vertex_i        (to_vertex_i),
    .edge_weight_i      (edge_weight_i),
    .empty              (empty),
    .pop                (pop),
    .found_o            (found_o),
    .neighbour_o        (neighbour_o),
    .neighbour_weight_o (neighbour_weight_o),
    .vertex_count_o     (vertex_count_o),
    .last_o             (last_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Watchdog. The limit sits far above the slowest legal run: every command
  // a full row listing, every result held back by the longest stall, plus the
  // matrix clearing sweep after reset.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Mostly back to back, sometimes a short gap, now and then a long one.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Weights lean on zero and the corners of the signed range; the rest are
  // uniform, so every bit of the field gets toggled.
  function automatic logic signed [WGT_W-1:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) begin
      case ($urandom_range(0, 3))
        0:       return 16'sh7FFF;
        1:       return 16'sh8000;
        2:       return 16'sh0001;
        default: return 16'shFFFF;
      endcase
    end
    return WGT_W'($urandom_range(0, 65535));
  endfunction

  // --------------------------------------------------------------------------
  // Result side. The block holds the oldest result on its ports while empty
  // is low; a transaction completes at an edge with pop high. Values are read
  // at the edge before any update of that edge takes effect.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_sink
    res_t got;
    bit taken;
    bit next_pop;
    int unsigned g;
    taken = pop && !empty;
    if (taken) begin
      got.found = found_o;
      got.neighbour = neighbour_o;
      got.neighbour_weight = neighbour_weight_o;
      got.vertex_count = vertex_count_o;
      got.last = last_o;
      sb.check_result(got);
      if ($urandom_range(0, 49) == 0) sink_calm = !sink_calm;
    end
    if (!rst_ni) begin
      next_pop = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      next_pop = 1'b0;
    end else begin
      next_pop = 1'b1;
      if (taken) begin
        g = pick_gap(sink_calm);
        if (g > 0) begin
          stall_left = g - 1;
          next_pop = 1'b0;
        end
      end
    end
    pop <= next_pop;
  end

  // --------------------------------------------------------------------------
  // Command side. Every call starts at a clock edge. push is left high after
  // a transaction, so that a following command with no gap goes out back to
  // back; whoever stops sending lowers it.
  // --------------------------------------------------------------------------
  task automatic send_item(op_e op, logic [VTX_W-1:0] a, logic [VTX_W-1:0] b,
                           logic signed [WGT_W-1:0] w);
    int unsigned gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    op_i <= op;
    from_vertex_i <= a;
    to_vertex_i <= b;
    edge_weight_i <= w;
    do @(posedge clk_i); while (full);
    sb.note_command(op, a, b, w);
  endtask

  // Stops sending and waits until the block has delivered everything it owes.
  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes the direction register, then reads it back. Only called while the
  // block has nothing in flight.
  task automatic write_mode(bit one_way);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MODE_ADDR;
    pwdata <= APB_DATA_W'(one_way);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.one_way = one_way;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== APB_DATA_W'(one_way)) begin
      sb.report($sformatf("directed_mode reads back %0h, want %0d", prdata, one_way));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Opening sequence: an empty graph first, then commands that reach outside
  // a small vertex count, then the corners of the vertex and weight ranges.
  task automatic run_directed();
    send_item(OP_HAS, 0, 0, 0);            // has edge on an empty graph
    send_item(OP_SCAN, 0, 0, 0);           // listing with no vertices
    send_item(OP_DEL, 0, 0, 0);            // delete with nothing in range
    send_item(OP_ADD, 2, 3, 16'sh7FFF);    // count grows to 4, mirrored
    send_item(OP_HAS, 3, 2, 0);            // mirrored entry is visible
    send_item(OP_HAS, 5, 1, 0);            // endpoint beyond the count
    send_item(OP_DEL, 1, 7, 0);            // delete beyond the count is a no-op
    send_item(OP_SCAN, 9, 0, 0);           // listing of a vertex beyond the count
    send_item(OP_SCAN, 2, 0, 0);
    send_item(OP_ADD, 5, 0, 0);            // zero weight still grows the count
    send_item(OP_SCAN, 5, 0, 0);           // row inside the count but empty
    send_item(OP_ADD, 0, 0, 16'sh8000);    // self loop, most negative weight
    send_item(OP_ADD, 0, 5, 16'sh5555);
    send_item(OP_ADD, 4, 1, 16'shAAAA);
    send_item(OP_SCAN, 0, 0, 0);
    send_item(OP_HAS, 1, 4, 0);
    send_item(OP_DEL, 4, 1, 0);
    send_item(OP_HAS, 1, 4, 0);
    send_item(OP_ADD, 31, 31, 16'sh0001);  // highest vertex, count reaches 32
    send_item(OP_ADD, 31, 0, 16'shFFFF);
    send_item(OP_SCAN, 31, 0, 0);
    send_item(OP_ADD, 2, 3, 0);            // zero weight removes the edge
    send_item(OP_HAS, 2, 3, 0);
    send_item(OP_SCAN, 0, 0, 0);
  endtask

  // Random commands. Most of them touch a few busy rows so that rows fill up
  // and listings return long runs; now and then a whole row is written and
  // listed, which gives the longest possible listing.
  task automatic run_random(int unsigned budget);
    logic [VTX_W-1:0] busy_rows [3];
    int unsigned sent;
    int unsigned fills;
    int unsigned r;
    logic [VTX_W-1:0] row;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    op_e op;
    logic signed [WGT_W-1:0] w;
    sent = 0;
    fills = 0;
    foreach (busy_rows[i]) busy_rows[i] = VTX_W'($urandom_range(0, VERTICES - 1));
    while (sent < budget) begin
      if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
      if (fills < 2 && budget - sent > 40 && $urandom_range(0, 99) < 4) begin
        row = busy_rows[$urandom_range(0, 2)];
        for (int unsigned j = 0; j < VERTICES; j++) begin
          do w = WGT_W'($urandom_range(0, 65535)); while (w == 0);
          send_item(OP_ADD, row, VTX_W'(j), w);
        end
        send_item(OP_SCAN, row, VTX_W'($urandom_range(0, 31)), pick_weight());
        sent += VERTICES + 1;
        fills++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_ADD;
        else if (r < 50) op = OP_DEL;
        else if (r < 75) op = OP_HAS;
        else op = OP_SCAN;
        a = ($urandom_range(0, 9) < 6) ? busy_rows[$urandom_range(0, 2)]
                                       : VTX_W'($urandom_range(0, 31));
        b = ($urandom_range(0, 9) < 4) ? busy_rows[$urandom_range(0, 2)]
                                       : VTX_W'($urandom_range(0, 31));
        send_item(op, a, b, pick_weight());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence. Reset is held first; the block then clears its matrix with
  // full held high, which send_item simply waits out. Phases alternate the
  // edge direction so that both settings see every operation, and the matrix
  // carries over from one phase to the next.
  // --------------------------------------------------------------------------
  initial begin : main_sequence
    int unsigned waited;
    sb = new();
    cycle_count <= 0;
    sender_calm = 1'b0;
    sink_calm = 1'b0;
    stall_left = 0;
    rst_ni <= 1'b0;
    push <= 1'b0;
    op_i <= OP_ADD;
    from_vertex_i <= '0;
    to_vertex_i <= '0;
    edge_weight_i <= '0;
    pop <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_mode(1'b0);
    run_directed();
    // The sender holds off here until every result has come back.
    drain_results();

    write_mode(1'b1);
    run_random(200);
    drain_results();

    write_mode(1'b0);
    run_random(200);
    drain_results();

    write_mode(1'b1);
    run_random(40);
    push <= 1'b0;

    // Wait for the remaining results, then a little longer so that anything
    // the block emits beyond them is caught as unexpected.
    waited = 0;
    while (sb.pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      sb.report($sformatf("%0d expected results never arrived", sb.pending_results.size()));
    end

    if (sb.fault_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/wams_pkg.sv
rtl/wams_ram.sv
rtl/wams_fifo.sv
rtl/wams_front.sv
rtl/wams_back.sv
rtl/weighted_adjacency_matrix_store_core.sv
test/testbench.sv
